@@ src/palette_nearest_color_table_defines.svh @@
// assertion macros shared by the palette table modules
`ifndef PALETTE_NEAREST_COLOR_TABLE_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_TABLE_DEFINES_SVH

// property checked in the same cycle
`define PNCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// property checked in the next cycle
`define PNCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pnct_pkg.sv @@
`timescale 1ns / 1ps

package pnct_pkg;

  localparam int unsigned NumEntriesDef = 256;
  localparam int unsigned ChW           = 10;
  localparam int unsigned IndexW        = 8;
  localparam int unsigned UsedW         = 9;
  localparam int unsigned ColourW       = 3 * ChW;
  localparam int unsigned SqW           = 2 * ChW;
  localparam int unsigned DistW         = SqW + 2;
  localparam int unsigned InDataW       = 40;
  localparam int unsigned OutDataW      = 24;

  localparam logic [ColourW-1:0] White = '1;

  localparam logic [1:0] OpAdd  = 2'd0;
  localparam logic [1:0] OpSet  = 2'd1;
  localparam logic [1:0] OpFind = 2'd2;

  typedef enum logic [1:0] {
    KindAdd,
    KindSet,
    KindSetSkip,
    KindFind
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [IndexW-1:0] index;
    logic [ChW-1:0]    blue;
    logic [ChW-1:0]    green;
    logic [ChW-1:0]    red;
  } cmd_t;

  function automatic logic [ChW-1:0] abs_diff(input logic [ChW-1:0] a, input logic [ChW-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ src/pnct_ram.sv @@
`timescale 1ns / 1ps

module pnct_ram #(
  parameter int unsigned Width = 30,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pnct_front.sv @@
`timescale 1ns / 1ps
`include "palette_nearest_color_table_defines.svh"

module pnct_front #(
  parameter int unsigned PaletteEntries = pnct_pkg::NumEntriesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [pnct_pkg::InDataW-1:0] s_axis_tdata,
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i,
  output pnct_pkg::cmd_t               cmd_o
);

  pnct_pkg::cmd_t cmd_in;
  pnct_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;
  logic [1:0]     op;

  // classify the incoming word
  always_comb begin
    op            = s_axis_tdata[1:0];
    cmd_in.index  = s_axis_tdata[9:2];
    cmd_in.red    = s_axis_tdata[19:10];
    cmd_in.green  = s_axis_tdata[29:20];
    cmd_in.blue   = s_axis_tdata[39:30];
    unique case (op)
      pnct_pkg::OpAdd:  cmd_in.kind = pnct_pkg::KindAdd;
      pnct_pkg::OpSet: begin
        if ({1'b0, cmd_in.index} < 9'(PaletteEntries)) begin
          cmd_in.kind = pnct_pkg::KindSet;
        end else begin
          cmd_in.kind = pnct_pkg::KindSetSkip;
        end
      end
      pnct_pkg::OpFind: cmd_in.kind = pnct_pkg::KindFind;
      default:          cmd_in.kind = pnct_pkg::KindFind;
    endcase
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign cmd_o         = mem_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  `PNCT_ASSERT_NOW(queue_depth_a, 1'b1, cnt_q <= 2'd2, "command queue overfilled")
  `PNCT_ASSERT_NEXT(queue_pop_a, pop && !push, cnt_q == $past(cnt_q) - 2'd1,
                    "queue count did not drop on pop")

endmodule

@@ src/pnct_back.sv @@
`timescale 1ns / 1ps
`include "palette_nearest_color_table_defines.svh"

module pnct_back #(
  parameter int unsigned PaletteEntries = pnct_pkg::NumEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  pnct_pkg::cmd_t                cmd_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pnct_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned AddrW = $clog2(PaletteEntries);
  localparam int unsigned CntW  = $clog2(PaletteEntries + 1);

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

  state_e                       state_q, state_d;
  logic [CntW-1:0]              used_q, used_d;
  logic [PaletteEntries-1:0]    valid_q, valid_d;
  logic [CntW-1:0]              scan_q, scan_d;
  logic                         p1_q, p1_d;
  logic                         p2_q, p2_d;
  logic                         out_valid_q, out_valid_d;
  logic [pnct_pkg::IndexW-1:0]  out_index_q, out_index_d;
  logic                         out_app_q, out_app_d;
  logic [pnct_pkg::UsedW-1:0]   out_used_q, out_used_d;

  logic [pnct_pkg::ColourW-1:0] col_q;
  logic [AddrW-1:0]             rd_idx_q, p2_idx_q, best_idx_q;
  logic                         rd_valid_q;
  logic [pnct_pkg::SqW-1:0]     sq_r_q, sq_g_q, sq_b_q;
  logic [pnct_pkg::DistW-1:0]   best_dist_q;

  logic                         out_free, fire, full, issue, ram_we;
  logic [AddrW-1:0]             ram_waddr, scan_addr;
  logic [pnct_pkg::ColourW-1:0] ram_wdata, ram_rdata, entry;
  logic [CntW-1:0]              set_top;
  logic [pnct_pkg::ChW-1:0]     dr, dg, db;
  logic [pnct_pkg::DistW-1:0]   cand_dist;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign cmd_ready_o = (state_q == StIdle) && out_free;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign full        = (used_q == CntW'(PaletteEntries));
  assign issue       = (state_q == StScan) && (scan_q < used_q);
  assign scan_addr   = scan_q[AddrW-1:0];
  assign set_top     = CntW'(cmd_i.index[AddrW-1:0]) + CntW'(1);
  assign ram_we      = fire && ((cmd_i.kind == pnct_pkg::KindSet) ||
                                ((cmd_i.kind == pnct_pkg::KindAdd) && !full));
  assign ram_waddr   = (cmd_i.kind == pnct_pkg::KindAdd) ? used_q[AddrW-1:0]
                                                         : cmd_i.index[AddrW-1:0];
  assign ram_wdata   = {cmd_i.blue, cmd_i.green, cmd_i.red};

  pnct_ram #(
    .Width (pnct_pkg::ColourW),
    .Depth (PaletteEntries)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_addr),
    .rdata_o (ram_rdata)
  );

  // never-written entries keep their reset colour
  always_comb begin
    if (rd_valid_q) begin
      entry = ram_rdata;
    end else if (rd_idx_q == '0) begin
      entry = pnct_pkg::White;
    end else begin
      entry = '0;
    end
    dr        = pnct_pkg::abs_diff(entry[9:0], col_q[9:0]);
    dg        = pnct_pkg::abs_diff(entry[19:10], col_q[19:10]);
    db        = pnct_pkg::abs_diff(entry[29:20], col_q[29:20]);
    cand_dist = pnct_pkg::DistW'(sq_r_q) + pnct_pkg::DistW'(sq_g_q) +
                pnct_pkg::DistW'(sq_b_q);
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    valid_d     = valid_q;
    scan_d      = scan_q;
    p1_d        = issue;
    p2_d        = p1_q;
    out_valid_d = out_valid_q;
    out_index_d = out_index_q;
    out_app_d   = out_app_q;
    out_used_d  = out_used_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (fire) begin
          unique case (cmd_i.kind)
            pnct_pkg::KindSet: begin
              valid_d[ram_waddr] = 1'b1;
              if (set_top > used_q) begin
                used_d = set_top;
              end
              out_valid_d = 1'b1;
              out_index_d = cmd_i.index;
              out_app_d   = 1'b0;
              out_used_d  = pnct_pkg::UsedW'(used_d);
            end
            pnct_pkg::KindSetSkip: begin
              out_valid_d = 1'b1;
              out_index_d = cmd_i.index;
              out_app_d   = 1'b0;
              out_used_d  = pnct_pkg::UsedW'(used_q);
            end
            pnct_pkg::KindAdd: begin
              if (!full) begin
                valid_d[ram_waddr] = 1'b1;
                used_d      = used_q + CntW'(1);
                out_valid_d = 1'b1;
                out_index_d = pnct_pkg::IndexW'(used_q);
                out_app_d   = 1'b1;
                out_used_d  = pnct_pkg::UsedW'(used_d);
              end else begin
                state_d = StScan;
                scan_d  = '0;
              end
            end
            pnct_pkg::KindFind: begin
              state_d = StScan;
              scan_d  = '0;
            end
          endcase
        end
      end
      StScan: begin
        if (issue) begin
          scan_d = scan_q + CntW'(1);
        end else if (!p1_q && !p2_q && out_free) begin
          out_valid_d = 1'b1;
          out_index_d = pnct_pkg::IndexW'(best_idx_q);
          out_app_d   = 1'b0;
          out_used_d  = pnct_pkg::UsedW'(used_q);
          state_d     = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= CntW'(1);
      valid_q     <= '0;
      scan_q      <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_index_q <= '0;
      out_app_q   <= 1'b0;
      out_used_q  <= '0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      valid_q     <= valid_d;
      scan_q      <= scan_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      out_valid_q <= out_valid_d;
      out_index_q <= out_index_d;
      out_app_q   <= out_app_d;
      out_used_q  <= out_used_d;
    end
  end

  // scan pipeline: read, square, accumulate
  always_ff @(posedge clk_i) begin
    if (fire) begin
      col_q       <= ram_wdata;
      best_dist_q <= '1;
      best_idx_q  <= '0;
    end else if (p2_q && (cand_dist < best_dist_q)) begin
      best_dist_q <= cand_dist;
      best_idx_q  <= p2_idx_q;
    end
    rd_idx_q   <= scan_addr;
    rd_valid_q <= valid_q[scan_addr];
    sq_r_q     <= pnct_pkg::SqW'(dr) * pnct_pkg::SqW'(dr);
    sq_g_q     <= pnct_pkg::SqW'(dg) * pnct_pkg::SqW'(dg);
    sq_b_q     <= pnct_pkg::SqW'(db) * pnct_pkg::SqW'(db);
    p2_idx_q   <= rd_idx_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_used_q, out_app_q, out_index_q};

  `PNCT_ASSERT_NOW(used_range_a, 1'b1,
                   (used_q != '0) && (used_q <= CntW'(PaletteEntries)),
                   "used count out of range")
  `PNCT_ASSERT_NOW(scan_out_empty_a, state_q == StScan, !out_valid_q,
                   "result pending during scan")
  `PNCT_ASSERT_NEXT(append_count_a, fire && (cmd_i.kind == pnct_pkg::KindAdd) && !full,
                    used_q == $past(used_q) + CntW'(1), "append did not raise used count")

endmodule

@@ src/palette_nearest_color_table.sv @@
`timescale 1ns / 1ps
// nearest-colour palette table
// input channel s_axis: one word per operation (add, set or find) with an rgb colour
// output channel m_axis: one word per input word, in order: index, appended flag,
// entries in use afterwards
// set and a non-full add finish in the cycle after leaving the command queue; find and an
// add to a full palette scan the used entries through the palette memory read port,
// one entry per cycle
// a two-word command queue keeps the input taking words while the back end works
// reset: palette holds only entry 0 (white), used count is one, both channels empty
// a stalled receiver holds the result register; the queue fills and then tready drops
module palette_nearest_color_table #(
  parameter int unsigned PaletteEntries = pnct_pkg::NumEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // operation[1:0], entry_index[9:2], red[19:10], green[29:20], blue[39:30]
  input  logic [pnct_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // result_index[7:0], appended[8], used_entries[17:9], zero[23:18]
  output logic [pnct_pkg::OutDataW-1:0] m_axis_tdata
);

  pnct_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_ready;

  pnct_front #(
    .PaletteEntries (PaletteEntries)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  pnct_back #(
    .PaletteEntries (PaletteEntries)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
